// ----- rtl/pmc_pkg.sv -----
// Shared constants, types and helpers for the pattern match counter.
package pmc_pkg;

    localparam int DATA_BITS    = 8;
    localparam int POS_BITS     = 32;
    localparam int OUT_CNT_BITS = 32;
    localparam int LEN_BITS     = 6;
    localparam int PAT_REGS     = 4;
    localparam int PAT_REG_BITS = 64;
    localparam int PAT_BYTES    = PAT_REGS * PAT_REG_BITS / DATA_BITS;
    localparam int PAT_SEL_BITS = $clog2(PAT_BYTES);
    localparam int PAT_VEC_BITS = PAT_REGS * PAT_REG_BITS;
    localparam int CFG_ADDR_BITS = 3;
    localparam int DEF_MAX_PATTERN = 32;
    localparam int DEF_COUNT_BITS  = 32;

    // Register indexes on the configuration port
    localparam logic [CFG_ADDR_BITS-1:0] REG_PATTERN_LENGTH = 3'd0;
    localparam logic [CFG_ADDR_BITS-1:0] REG_PATTERN_BYTES_0 = 3'd1;
    localparam logic [CFG_ADDR_BITS-1:0] REG_PATTERN_BYTES_1 = 3'd2;
    localparam logic [CFG_ADDR_BITS-1:0] REG_PATTERN_BYTES_2 = 3'd3;
    localparam logic [CFG_ADDR_BITS-1:0] REG_PATTERN_BYTES_3 = 3'd4;

    localparam logic [LEN_BITS-1:0] LEN_RESET = 6'd1;

    // Per-cycle control handed to every window cell
    typedef struct packed {
        logic shift;
        logic clear;
    } cell_ctrl_t;

    function automatic logic [DATA_BITS-1:0] pattern_byte(
        input logic [PAT_VEC_BITS-1:0] vec,
        input logic [PAT_SEL_BITS-1:0] sel
    );
        pattern_byte = vec[sel*DATA_BITS +: DATA_BITS];
    endfunction

endpackage

// ----- rtl/pmc_cell.sv -----
// One window cell: holds a byte, passes it on, and checks it against its pattern byte.
module pmc_cell
    import pmc_pkg::*;
#(
    parameter int IDX = 0
) (
    input  logic                    aclk,
    input  cell_ctrl_t              ctrl,
    input  logic [DATA_BITS-1:0]    byte_in,
    input  logic [PAT_VEC_BITS-1:0] pat_vec,
    input  logic [LEN_BITS-1:0]     len,
    output logic [DATA_BITS-1:0]    byte_out,
    output logic                    ok
);

    logic [DATA_BITS-1:0]    byte_reg;
    logic [DATA_BITS-1:0]    byte_next;
    logic                    in_use;
    logic [PAT_SEL_BITS-1:0] sel;

    // Cell zero always takes the new byte; the rest drop to zero on a new buffer
    always_comb begin
        byte_next = byte_reg;
        if (ctrl.shift) begin
            if (ctrl.clear && IDX != 0) begin
                byte_next = '0;
            end else begin
                byte_next = byte_in;
            end
        end
    end

    always_ff @(posedge aclk) begin
        byte_reg <= byte_next;
    end

    // Newest byte lines up with the last pattern byte
    assign in_use = LEN_BITS'(IDX) < len;
    assign sel    = PAT_SEL_BITS'(len - LEN_BITS'(IDX) - LEN_BITS'(1));
    assign ok     = !in_use || (byte_reg == pattern_byte(pat_vec, sel));
    assign byte_out = byte_reg;

endmodule

// ----- rtl/pattern_match_counter.sv -----
// Top level: window cell chain, position and match tally, output register.
//
// Usage: bytes of a buffer enter on the s_ channel, one request per byte;
// s_tuser marks the first byte of a buffer and clears the window, the
// position and the total. Each byte yields exactly one result on the m_
// channel: whether the newest pattern_length bytes equal the pattern, the
// buffer index where that match starts, the saturating running total, and
// s_tlast passed through as m_tlast.
// Pipeline: an accepted byte sits in the compare stage, then its result moves into the output register.
// Throughput: one byte per cycle while m_tready is high; the window is a row of MAX_PATTERN
// cells that shift together and compare in parallel, and the tally stage adds at
// most one per cycle.
// Stall: when m_tready is low the output register holds, the compare stage
// holds, and s_tready drops once both are full; nothing is lost or repeated.
// Reset: pattern_length 1, pattern bytes zero, position and total zero.
// Configuration is written through cfg_we/cfg_addr/cfg_wdata while idle;
// indexes beyond the register list are ignored.
module pattern_match_counter
    import pmc_pkg::*;
#(
    parameter int MAX_PATTERN = DEF_MAX_PATTERN,
    parameter int COUNT_BITS  = DEF_COUNT_BITS
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_tvalid,
    output logic                     s_tready,
    input  logic [7:0]               s_tdata,   // [7:0] data_byte
    input  logic                     s_tuser,   // [0] first_byte
    input  logic                     s_tlast,   // last_byte
    output logic                     m_tvalid,
    input  logic                     m_tready,
    output logic [63:0]              m_tdata,   // [31:0] match_start, [63:32] match_tally
    output logic                     m_tuser,   // [0] match_here
    output logic                     m_tlast,   // total_final
    input  logic                     cfg_we,
    input  logic [CFG_ADDR_BITS-1:0] cfg_addr,
    input  logic [PAT_REG_BITS-1:0]  cfg_wdata
);

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
    localparam logic [POS_BITS-1:0]   POS_MAX   = '1;

    // Configuration
    logic [LEN_BITS-1:0]     len_reg;
    logic [PAT_REG_BITS-1:0] pat_reg [PAT_REGS];
    logic [PAT_VEC_BITS-1:0] pat_vec;
    logic [LEN_BITS-1:0]     len_eff;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_reg <= LEN_RESET;
            for (int i = 0; i < PAT_REGS; i++) begin
                pat_reg[i] <= '0;
            end
        end else if (cfg_we) begin
            unique case (cfg_addr)
                REG_PATTERN_LENGTH:  len_reg    <= cfg_wdata[LEN_BITS-1:0];
                REG_PATTERN_BYTES_0: pat_reg[0] <= cfg_wdata;
                REG_PATTERN_BYTES_1: pat_reg[1] <= cfg_wdata;
                REG_PATTERN_BYTES_2: pat_reg[2] <= cfg_wdata;
                REG_PATTERN_BYTES_3: pat_reg[3] <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        for (int i = 0; i < PAT_REGS; i++) begin
            pat_vec[i*PAT_REG_BITS +: PAT_REG_BITS] = pat_reg[i];
        end
    end

    // Clamp the length into 1..MAX_PATTERN
    always_comb begin
        if (len_reg == '0) begin
            len_eff = LEN_BITS'(1);
        end else if (len_reg > LEN_BITS'(MAX_PATTERN)) begin
            len_eff = LEN_BITS'(MAX_PATTERN);
        end else begin
            len_eff = len_reg;
        end
    end

    // Handshake: compare stage advances when the output register is free
    logic a_valid_reg;
    logic m_valid_reg;
    logic advance;
    logic s_accept;

    assign advance  = !m_valid_reg || m_tready;
    assign s_tready = !a_valid_reg || advance;
    assign s_accept = s_tvalid && s_tready;

    // Cell chain
    cell_ctrl_t           ctrl;
    logic [DATA_BITS-1:0] chain [MAX_PATTERN+1];
    logic [MAX_PATTERN-1:0] cell_ok;

    assign ctrl.shift = s_accept;
    assign ctrl.clear = s_tuser;
    assign chain[0]   = s_tdata;

    for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_cell
        pmc_cell #(
            .IDX(k)
        ) u_cell (
            .aclk    (aclk),
            .ctrl    (ctrl),
            .byte_in (chain[k]),
            .pat_vec (pat_vec),
            .len     (len_eff),
            .byte_out(chain[k+1]),
            .ok      (cell_ok[k])
        );
    end

    // Position tracking for the item in the compare stage
    logic [POS_BITS-1:0] seen_reg;
    logic [POS_BITS-1:0] seen_next;
    logic [POS_BITS-1:0] a_idx_reg;
    logic [POS_BITS-1:0] idx_new;
    logic                a_first_reg;
    logic                a_last_reg;

    assign idx_new = s_tuser ? '0 : seen_reg;

    always_comb begin
        seen_next = seen_reg;
        if (s_accept) begin
            seen_next = (idx_new == POS_MAX) ? idx_new : idx_new + POS_BITS'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seen_reg    <= '0;
            a_valid_reg <= 1'b0;
        end else begin
            seen_reg <= seen_next;
            if (s_accept) begin
                a_valid_reg <= 1'b1;
            end else if (advance) begin
                a_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            a_idx_reg   <= idx_new;
            a_first_reg <= s_tuser;
            a_last_reg  <= s_tlast;
        end
    end

    // Tally stage
    logic                  hit;
    logic                  long_enough;
    logic [POS_BITS-1:0]   start;
    logic [COUNT_BITS-1:0] total_reg;
    logic [COUNT_BITS-1:0] total_base;
    logic [COUNT_BITS-1:0] total_next;
    logic                  tally;

    assign tally       = a_valid_reg && advance;
    assign long_enough = ({1'b0, a_idx_reg} + (POS_BITS+1)'(1)) >= (POS_BITS+1)'(len_eff);
    assign hit         = long_enough && (&cell_ok);
    assign start       = hit ? a_idx_reg - POS_BITS'(len_eff - LEN_BITS'(1)) : '0;
    assign total_base  = a_first_reg ? '0 : total_reg;

    always_comb begin
        total_next = total_reg;
        if (tally) begin
            total_next = (hit && total_base != COUNT_MAX)
                       ? total_base + COUNT_BITS'(1) : total_base;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            total_reg <= '0;
        end else begin
            total_reg <= total_next;
        end
    end

    // Saturate the total to the output width
    logic [OUT_CNT_BITS-1:0] total_out;

    if (COUNT_BITS > OUT_CNT_BITS) begin : g_sat
        assign total_out = (|total_next[COUNT_BITS-1:OUT_CNT_BITS])
                         ? '1 : total_next[OUT_CNT_BITS-1:0];
    end else begin : g_ext
        assign total_out = OUT_CNT_BITS'(total_next);
    end

    // Output register
    logic                    m_hit_reg;
    logic [POS_BITS-1:0]     m_start_reg;
    logic [OUT_CNT_BITS-1:0] m_total_reg;
    logic                    m_last_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance) begin
            m_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (tally) begin
            m_hit_reg   <= hit;
            m_start_reg <= start;
            m_total_reg <= total_out;
            m_last_reg  <= a_last_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {m_total_reg, m_start_reg};
    assign m_tuser  = m_hit_reg;
    assign m_tlast  = m_last_reg;

    // Checks
    a_hit_counts: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tdata[63:32] != '0)
        else $error("match reported with zero total");

    a_miss_start: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> m_tdata[31:0] == '0)
        else $error("start index set without a match");

    a_new_buffer: assert property (@(posedge aclk) disable iff (!aresetn)
        tally && a_first_reg && !hit |=> m_tdata[63:32] == '0)
        else $error("total not cleared at buffer start");

    a_pos_step: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept && !s_tuser && seen_reg != POS_MAX |=> seen_reg == $past(seen_reg) + 1'b1)
        else $error("position did not advance by one");

endmodule
